@@ rtl/core/adq_pkg.sv @@
`default_nettype none

package adq_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int WORD_W      = 32;
   localparam int KIND_W      = 3;
   localparam int STATUS_W    = 2;
   localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
   // signed index wide enough for -1 .. QUEUE_DEPTH
   localparam int IDX_W       = $clog2(QUEUE_DEPTH + 1) + 1;

   localparam logic signed [IDX_W-1:0] LAST_SLOT   = IDX_W'(QUEUE_DEPTH - 1);
   localparam logic signed [IDX_W-1:0] FRONT_LIMIT = IDX_W'(QUEUE_DEPTH);

   // request queue between front and back
   localparam int QUEUE_SLOTS = 2;
   localparam int QPTR_W      = $clog2(QUEUE_SLOTS);
   localparam int QCNT_W      = $clog2(QUEUE_SLOTS + 1);

   typedef enum logic [KIND_W-1:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_REAR  = 3'd1,
      OP_DEL_FRONT = 3'd2,
      OP_DEL_REAR  = 3'd3,
      OP_LIST      = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_EMPTY   = 2'd2,
      STATUS_NOFRONT = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_LIST
   } state_type;

   typedef struct packed {
      logic              valid;
      op_type            op;
      logic [WORD_W-1:0] value;
   } head_type;

endpackage

`default_nettype wire

@@ rtl/core/adq_ram.sv @@
`default_nettype none

module adq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold read data until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/adq_front.sv @@
`default_nettype none

module adq_front
   import adq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [KIND_W-1:0]        req_kind,
   input  logic signed [WORD_W-1:0] req_value,
   output head_type                 head,
   input  logic                     head_pop
);

   op_type            op_ff    [QUEUE_SLOTS];
   logic [WORD_W-1:0] value_ff [QUEUE_SLOTS];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   logic   kind_ok;
   op_type kind_op;
   logic   push;

   // classify: unused kinds are accepted and dropped
   always_comb begin
      kind_ok = 1'b1;
      kind_op = OP_INS_FRONT;
      unique case (req_kind)
         OP_INS_FRONT: kind_op = OP_INS_FRONT;
         OP_INS_REAR:  kind_op = OP_INS_REAR;
         OP_DEL_FRONT: kind_op = OP_DEL_FRONT;
         OP_DEL_REAR:  kind_op = OP_DEL_REAR;
         OP_LIST:      kind_op = OP_LIST;
         default:      kind_ok = 1'b0;
      endcase
   end

   assign req_stall = (count_ff == QCNT_W'(QUEUE_SLOTS));
   assign push      = req_valid && !req_stall && kind_ok;

   always_comb begin
      wr_ptr_in = push     ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = head_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      priority if (push && !head_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!push && head_pop) begin
         count_in = count_ff - QCNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         op_ff[wr_ptr_ff]    <= kind_op;
         value_ff[wr_ptr_ff] <= req_value;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.op    = op_ff[rd_ptr_ff];
   assign head.value = value_ff[rd_ptr_ff];

   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> count_ff != '0)
      else $error("pop from empty request queue");

endmodule

`default_nettype wire

@@ rtl/core/adq_back.sv @@
`default_nettype none

module adq_back
   import adq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  head_type                 head,
   output logic                     head_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic signed [WORD_W-1:0] rsp_data,
   output logic                     rsp_last
);

   state_type state_ff, state_in;
   logic signed [IDX_W-1:0] front_ff, front_in;
   logic signed [IDX_W-1:0] rear_ff, rear_in;
   logic [ADDR_W-1:0]       walk_ff, walk_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [WORD_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                rsp_last_ff, rsp_last_in;

   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [WORD_W-1:0] rd_data;

   logic empty;
   logic out_free;
   logic walk_last;

   assign empty     = front_ff > rear_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign walk_last = (walk_ff == rear_ff[ADDR_W-1:0]);

   adq_ram #(
      .WIDTH(WORD_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(head.value),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      front_in      = front_ff;
      rear_in       = rear_ff;
      walk_in       = walk_ff;
      head_pop      = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = rear_ff[ADDR_W-1:0] + ADDR_W'(1);
      rd_en         = 1'b0;
      rd_addr       = front_ff[ADDR_W-1:0];
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (head.valid && out_free) begin
               head_pop      = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_data_in   = '0;
               rsp_last_in   = 1'b1;
               unique case (head.op)
                  OP_INS_FRONT: begin
                     rsp_valid_in = 1'b1;
                     priority if (front_ff == '0 && rear_ff == LAST_SLOT) begin
                        rsp_status_in = STATUS_FULL;
                     end else if (empty) begin
                        if (rear_ff == LAST_SLOT) begin
                           rsp_status_in = STATUS_FULL;
                        end else begin
                           wr_en   = 1'b1;
                           rear_in = rear_ff + IDX_W'(1);
                        end
                     end else if (front_ff > '0) begin
                        wr_en    = 1'b1;
                        wr_addr  = front_ff[ADDR_W-1:0] - ADDR_W'(1);
                        front_in = front_ff - IDX_W'(1);
                     end else begin
                        rsp_status_in = STATUS_NOFRONT;
                     end
                  end
                  OP_INS_REAR: begin
                     rsp_valid_in = 1'b1;
                     if (rear_ff == LAST_SLOT) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        rear_in = rear_ff + IDX_W'(1);
                     end
                  end
                  OP_DEL_FRONT, OP_DEL_REAR: begin
                     if (empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = S_READ;
                        if (head.op == OP_DEL_FRONT) begin
                           front_in = front_ff + IDX_W'(1);
                        end else begin
                           rd_addr = rear_ff[ADDR_W-1:0];
                           rear_in = rear_ff - IDX_W'(1);
                        end
                     end
                  end
                  OP_LIST: begin
                     if (empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        walk_in  = front_ff[ADDR_W-1:0];
                        state_in = S_LIST;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b0;
                  end
               endcase
            end
         end
         S_READ: begin
            // output slot was freed when the delete was popped
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_data_in   = rd_data;
            rsp_last_in   = 1'b1;
            state_in      = S_IDLE;
         end
         S_LIST: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_data_in   = rd_data;
               rsp_last_in   = walk_last;
               if (walk_last) begin
                  state_in = S_IDLE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = walk_ff + ADDR_W'(1);
                  walk_in = walk_ff + ADDR_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         rear_ff      <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         rear_ff      <= rear_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff       <= walk_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_last   = rsp_last_ff;

   a_read_slot_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |-> !rsp_valid_ff)
      else $error("delete result would overwrite a pending item");

   a_front_range: assert property (@(posedge clock) disable iff (reset)
      front_ff >= 0 && front_ff <= FRONT_LIMIT)
      else $error("front index out of range");

   a_rear_range: assert property (@(posedge clock) disable iff (reset)
      rear_ff >= -1 && rear_ff <= LAST_SLOT)
      else $error("rear index out of range");

   a_list_not_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LIST |-> !empty && $stable(front_ff) && $stable(rear_ff))
      else $error("queue changed or emptied during a list walk");

endmodule

`default_nettype wire

@@ rtl/core/array_double_ended_queue_unit.sv @@
// Non-circular double-ended queue of signed 32-bit words.
// Request channel (req_valid / req_stall): req_kind selects insert front,
// insert rear, delete front, delete rear or list; req_value is the word to
// insert. Unused kinds are taken and dropped without a result.
// Result channel (rsp_valid / rsp_stall): rsp_status, rsp_data, rsp_last.
// Every other request gives one item with rsp_last set, except a list of a
// non-empty queue, which gives one item per stored word, front to rear,
// with rsp_last on the final one.
// Requests enter a two-entry queue and are carried out one at a time.
// Inserts are carried out as they are popped; a delete passes through a read
// state, as the store has a registered read port, and a list gives one word a
// cycle while the result is not stalled. Results are registered; a delete or
// the first listed word also passes through the store's read register.
// Reset (synchronous, active high) empties the queue: front index 0, rear
// index -1. Store contents are left as they are.
// While rsp_stall is high the result item holds; the block keeps taking
// requests until its request queue is full, then raises req_stall.
`default_nettype none

module array_double_ended_queue_unit
   import adq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [KIND_W-1:0]        req_kind,
   input  logic signed [WORD_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic signed [WORD_W-1:0] rsp_data,
   output logic                     rsp_last
);

   // head of the request queue, handed from decode to execution
   head_type head;
   logic     head_pop;

   // front: accept, classify and buffer requests
   adq_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind (req_kind),
      .req_value(req_value),
      .head     (head),
      .head_pop (head_pop)
   );

   // back: hold the indices and store, execute and drive results
   adq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .head_pop  (head_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_status(rsp_status),
      .rsp_data  (rsp_data),
      .rsp_last  (rsp_last)
   );

endmodule

`default_nettype wire

@@ sim/array_double_ended_queue_unit_test.sv @@
`timescale 1ns / 100ps

module array_double_ended_queue_unit_test;
   import adq_pkg::*;

   // Kinds outside the operation set: the block takes them and gives no result.
   localparam logic [KIND_W-1:0] KIND_SPARE_5 = 3'd5;
   localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

   // How a directed row is checked: against the predictor, or against the
   // single result typed into the row.
   localparam logic CHECK_MODEL = 1'b0;
   localparam logic CHECK_FIXED = 1'b1;

   localparam int LONG_HOLD   = 150;
   localparam int TAIL_CYCLES = 16;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      status_type               status;
      logic signed [WORD_W-1:0] data;
      logic                     last;
   } deque_reply;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [WORD_W-1:0] value;
      logic              check;
      status_type        status;
      logic [WORD_W-1:0] data;
   } step_row;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [KIND_W-1:0]        req_kind = '0;
   logic signed [WORD_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [STATUS_W-1:0]      rsp_status;
   logic signed [WORD_W-1:0] rsp_data;
   logic                     rsp_last;

   // Predictor state: the array, its two indices and the results owed.
   logic signed [WORD_W-1:0] deque_mem [QUEUE_DEPTH];
   int                       head_idx = 0;
   int                       tail_idx = -1;
   deque_reply               pending_replies [$];

   // Traffic shaping for the sender and the receiver.
   bit no_idle       = 1'b0;
   bit sender_burst  = 1'b0;
   bit long_hold_req = 1'b0;

   int error_count    = 0;
   int requests_sent  = 0;
   int replies_seen   = 0;
   int long_holds     = 0;
   int cycle_count    = 0;
   int status_seen [4] = '{0, 0, 0, 0};

   // Directed items: empty-queue errors first, then the extremes of the word,
   // front insertion into an empty queue (lands at the rear), front insertion
   // refused at index zero, and the unused kinds.
   step_row directed_rows [24] = '{
      '{OP_LIST,      32'h0000_0000, CHECK_FIXED, STATUS_EMPTY,   32'h0000_0000},
      '{OP_DEL_FRONT, 32'h0000_0000, CHECK_FIXED, STATUS_EMPTY,   32'h0000_0000},
      '{OP_DEL_REAR,  32'h0000_0000, CHECK_FIXED, STATUS_EMPTY,   32'h0000_0000},
      '{OP_INS_FRONT, 32'h7FFF_FFFF, CHECK_FIXED, STATUS_OK,      32'h0000_0000},
      '{OP_INS_FRONT, 32'h0000_0005, CHECK_FIXED, STATUS_NOFRONT, 32'h0000_0000},
      '{OP_INS_REAR,  32'h8000_0000, CHECK_FIXED, STATUS_OK,      32'h0000_0000},
      '{OP_LIST,      32'h0000_0000, CHECK_MODEL, STATUS_OK,      32'h0000_0000},
      '{OP_DEL_FRONT, 32'h0000_0000, CHECK_FIXED, STATUS_OK,      32'h7FFF_FFFF},
      '{OP_INS_FRONT, 32'hFFFF_FFFF, CHECK_MODEL, STATUS_OK,      32'h0000_0000},
      '{KIND_SPARE_5, 32'h1234_5678, CHECK_MODEL, STATUS_OK,      32'h0000_0000},
      '{KIND_SPARE_6, 32'h0000_0000, CHECK_MODEL, STATUS_OK,      32'h0000_0000},
      '{KIND_SPARE_7, 32'hFFFF_FFFF, CHECK_MODEL, STATUS_OK,      32'h0000_0000},
      '{OP_INS_REAR,  32'h0000_0000, CHECK_MODEL, STATUS_OK,      32'h0000_0000},
      '{OP_LIST,      32'h0000_0000, CHECK_MODEL, STATUS_OK,      32'h0000_0000},
      '{OP_DEL_REAR,  32'h0000_0000, CHECK_MODEL, STATUS_OK,      32'h0000_0000},
      '{OP_DEL_REAR,  32'h0000_0000, CHECK_FIXED, STATUS_OK,      32'h8000_0000},
      '{OP_DEL_FRONT, 32'h0000_0000, CHECK_MODEL, STATUS_OK,      32'h0000_0000},
      '{OP_DEL_FRONT, 32'h0000_0000, CHECK_FIXED, STATUS_EMPTY,   32'h0000_0000},
      '{OP_INS_FRONT, 32'h5555_5555, CHECK_MODEL, STATUS_OK,      32'h0000_0000},
      '{OP_INS_REAR,  32'hAAAA_AAAA, CHECK_MODEL, STATUS_OK,      32'h0000_0000},
      '{OP_LIST,      32'h0000_0000, CHECK_MODEL, STATUS_OK,      32'h0000_0000},
      '{OP_DEL_REAR,  32'h0000_0000, CHECK_MODEL, STATUS_OK,      32'h0000_0000},
      '{OP_DEL_FRONT, 32'h0000_0000, CHECK_MODEL, STATUS_OK,      32'h0000_0000},
      '{OP_LIST,      32'h0000_0000, CHECK_FIXED, STATUS_EMPTY,   32'h0000_0000}
   };

   array_double_ended_queue_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_kind   (req_kind),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_status (rsp_status),
      .rsp_data   (rsp_data),
      .rsp_last   (rsp_last)
   );

   always #10 clock = ~clock;

   // Queue one owed result, unless the caller supplies its own.
   function void add_reply(input bit keep, input status_type status,
                           input logic signed [WORD_W-1:0] data, input logic last);
      deque_reply r;
      r.status = status;
      r.data   = data;
      r.last   = last;
      if (keep) begin
         pending_replies.push_back(r);
      end
   endfunction

   // Advance the predicted deque by one accepted item and owe its results.
   function void deque_apply(input logic [KIND_W-1:0] kind,
                             input logic signed [WORD_W-1:0] value, input bit keep);
      status_type               status;
      logic signed [WORD_W-1:0] word;
      int                       i;
      status = STATUS_OK;
      word   = '0;
      case (kind)
         OP_INS_FRONT: begin
            if (head_idx == 0 && tail_idx == QUEUE_DEPTH - 1) begin
               status = STATUS_FULL;
            end else if (head_idx > tail_idx) begin
               // empty: the word goes to the rear, unless the rear is at the end
               if (tail_idx >= QUEUE_DEPTH - 1) begin
                  status = STATUS_FULL;
               end else begin
                  tail_idx++;
                  deque_mem[tail_idx] = value;
               end
            end else if (head_idx > 0) begin
               head_idx--;
               deque_mem[head_idx] = value;
            end else begin
               status = STATUS_NOFRONT;
            end
         end
         OP_INS_REAR: begin
            if (tail_idx >= QUEUE_DEPTH - 1) begin
               status = STATUS_FULL;
            end else begin
               tail_idx++;
               deque_mem[tail_idx] = value;
            end
         end
         OP_DEL_FRONT: begin
            if (head_idx > tail_idx) begin
               status = STATUS_EMPTY;
            end else begin
               word = deque_mem[head_idx];
               head_idx++;
            end
         end
         OP_DEL_REAR: begin
            if (head_idx > tail_idx) begin
               status = STATUS_EMPTY;
            end else begin
               word = deque_mem[tail_idx];
               tail_idx--;
            end
         end
         OP_LIST: begin
            if (head_idx > tail_idx) begin
               add_reply(keep, STATUS_EMPTY, '0, 1'b1);
            end else begin
               for (i = head_idx; i <= tail_idx; i++) begin
                  add_reply(keep, STATUS_OK, deque_mem[i], i == tail_idx);
               end
            end
            return;
         end
         default: begin
            return;
         end
      endcase
      add_reply(keep, status, word, 1'b1);
   endfunction

   // Draw a kind by weight; the last weight covers the unused kinds.
   function automatic logic [KIND_W-1:0] pick_kind(input int w_ins_front, input int w_ins_rear,
                                                   input int w_del_front, input int w_del_rear,
                                                   input int w_list, input int w_spare);
      int roll;
      roll = $urandom_range(0, w_ins_front + w_ins_rear + w_del_front + w_del_rear
                               + w_list + w_spare - 1);
      if (roll < w_ins_front) return OP_INS_FRONT;
      roll -= w_ins_front;
      if (roll < w_ins_rear) return OP_INS_REAR;
      roll -= w_ins_rear;
      if (roll < w_del_front) return OP_DEL_FRONT;
      roll -= w_del_front;
      if (roll < w_del_rear) return OP_DEL_REAR;
      roll -= w_del_rear;
      if (roll < w_list) return OP_LIST;
      case ($urandom_range(0, 2))
         0:       return KIND_SPARE_5;
         1:       return KIND_SPARE_6;
         default: return KIND_SPARE_7;
      endcase
   endfunction

   // Mostly random words, with the extremes, zero and the all-ones pattern mixed in.
   function automatic logic [WORD_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   // Offer one item after a random gap unless idling is off, hold it until taken, then predict it.
   task automatic offer(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] value,
                        input bit keep);
      int gap;
      gap = (no_idle || sender_burst) ? 0 : $urandom_range(0, 9);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_value <= value;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      deque_apply(kind, value, keep);
      requests_sent++;
   endtask

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $time, what);
      error_count++;
   endtask

   // Receiver: stall a random number of cycles before each result item, or a
   // long stretch on request so the block fills and stalls its input.
   initial begin
      int hold;
      wait (!reset);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold          = LONG_HOLD;
            long_holds++;
         end else begin
            hold = no_idle ? 0 : $urandom_range(0, 9);
         end
         if (hold > 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (hold - 1) @(negedge clock);
            @(negedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         while (!rsp_valid) begin
            @(posedge clock);
         end
      end
   end

   // Check every accepted result item against the oldest owed result.
   always @(posedge clock) begin
      deque_reply want;
      if (!reset && rsp_valid && !rsp_stall) begin
         replies_seen++;
         if (pending_replies.size() == 0) begin
            report_mismatch($sformatf("unexpected result item status=%0d data=%0d last=%0d",
                                      rsp_status, rsp_data, rsp_last));
         end else begin
            want = pending_replies.pop_front();
            status_seen[want.status]++;
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d", rsp_status, want.status));
            if (rsp_data !== want.data)
               report_mismatch($sformatf("data %0d, expected %0d", rsp_data, want.data));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last %0d, expected %0d", rsp_last, want.last));
         end
      end
   end

   // Give up on a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still owed",
                  cycle_count, pending_replies.size());
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      int row;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Directed items: typed rows owe their one typed result, the rest the
      // predictor's.
      for (row = 0; row < 24; row++) begin
         offer(directed_rows[row].kind, directed_rows[row].value,
               directed_rows[row].check == CHECK_MODEL);
         if (directed_rows[row].check == CHECK_FIXED) begin
            add_reply(1'b1, directed_rows[row].status, directed_rows[row].data, 1'b1);
         end
      end

      // Mixed traffic over a shallow queue.
      repeat (12) offer(pick_kind(20, 25, 15, 15, 10, 5), pick_value(), 1'b1);

      // Hold the receiver off while items keep coming back to back, so the
      // result path and then the request queue back up.
      long_hold_req = 1'b1;
      sender_burst  = 1'b1;
      repeat (12) offer(pick_kind(10, 40, 10, 10, 20, 0), pick_value(), 1'b1);
      sender_burst = 1'b0;

      // Pause the sender until every owed result has come back; drop valid
      // first so the last item is not offered again.
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) offer(pick_kind(20, 25, 15, 15, 10, 5), pick_value(), 1'b1);

      // Fill the rear to the last slot, the first half with no idling at all.
      no_idle = 1'b1;
      while (tail_idx < QUEUE_DEPTH - 1) begin
         if (tail_idx >= QUEUE_DEPTH / 2) no_idle = 1'b0;
         offer(pick_kind(8, 85, 0, 0, 4, 3), pick_value(), 1'b1);
      end
      no_idle = 1'b0;
      offer(OP_INS_REAR, pick_value(), 1'b1);
      // Push the front back down to index zero, then hit the full queue.
      while (head_idx > 0) begin
         offer(OP_INS_FRONT, pick_value(), 1'b1);
      end
      offer(OP_INS_FRONT, pick_value(), 1'b1);
      offer(OP_LIST, pick_value(), 1'b1);

      // Drain from the front only, so the queue runs empty with the rear
      // still at the last slot; any insert must then report full.
      while (head_idx <= tail_idx) begin
         offer(pick_kind(0, 0, 92, 0, 4, 4), pick_value(), 1'b1);
      end
      offer(OP_INS_FRONT, pick_value(), 1'b1);
      offer(OP_INS_REAR, pick_value(), 1'b1);
      offer(OP_DEL_FRONT, pick_value(), 1'b1);
      offer(OP_DEL_REAR, pick_value(), 1'b1);
      offer(OP_LIST, pick_value(), 1'b1);

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run: %0d requests, %0d result items, %0d long receiver hold(s), %0d mismatch(es)",
               requests_sent, replies_seen, long_holds, error_count);
      $display("run: status ok %0d, full %0d, empty %0d, front refused %0d",
               status_seen[STATUS_OK], status_seen[STATUS_FULL],
               status_seen[STATUS_EMPTY], status_seen[STATUS_NOFRONT]);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
